[rtl/emr_pkg.sv]
`default_nettype none
package emr_pkg;

   localparam int COORD_BITS = 16;
   localparam int ACC_BITS   = 52;
   localparam int GRAD_BITS  = 50;
   localparam int SQ_BITS    = 30;
   localparam int STEP_BITS  = 17;
   localparam int AXIS_BITS  = 15;
   localparam int MUL_A_BITS = 54;
   localparam int MUL_B_BITS = 36;
   localparam int CSR_BITS   = 2;
   localparam int COLOR_BITS = 32;

   // register indexes
   localparam logic [CSR_BITS-1:0] CSR_OUTLINE = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_FILL    = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_PEN     = 2'd2;
   localparam logic [CSR_BITS-1:0] CSR_FCOLOR  = 2'd3;

   // request functions
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   // result kinds
   localparam logic KIND_SPAN  = 1'b0;
   localparam logic KIND_POINT = 1'b1;

   // region codes
   localparam logic [1:0] REGION_IDLE = 2'd0;
   localparam logic [1:0] REGION_ONE  = 2'd1;
   localparam logic [1:0] REGION_TWO  = 2'd2;

   // multiply operations of the set-up sequences
   typedef enum logic [2:0] {
      OP_RX2 = 3'd0,
      OP_RY2 = 3'd1,
      OP_GY  = 3'd2,
      OP_TX2 = 3'd3,
      OP_T1  = 3'd4,
      OP_AY2 = 3'd5,
      OP_T2  = 3'd6,
      OP_T3  = 3'd7
   } mul_op_type;

   typedef struct packed {
      logic                  func;
      logic [COORD_BITS-1:0] origin_x;
      logic [COORD_BITS-1:0] origin_y;
      logic [COORD_BITS-1:0] rect_width;
      logic [COORD_BITS-1:0] rect_height;
   } req_type;

   typedef struct packed {
      logic                  kind;
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] x_first;
      logic [COORD_BITS-1:0] x_last;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
      logic                  finished;
   } rsp_type;

   typedef struct packed {
      logic       start;
      logic       step;
      logic       decide;
      logic       emit;
      logic [2:0] slot;
      logic       last;
      logic       finished;
      logic       mul_load;
      logic       mul_commit;
      mul_op_type op;
      logic [1:0] region;
   } cmd_type;

   typedef struct packed {
      logic outline_en;
      logic fill_en;
      logic py_zero;
      logic sy_neg;
      logic gx_ge_gy;
      logic mul_busy;
   } status_type;

endpackage
`default_nettype wire

[rtl/emr_mul.sv]
`default_nettype none
module emr_mul (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           load,
   input  wire logic [emr_pkg::MUL_A_BITS-1:0] a,
   input  wire logic [emr_pkg::MUL_B_BITS-1:0] b,
   output logic                                busy,
   output logic      [emr_pkg::MUL_A_BITS-1:0] prod
);
   import emr_pkg::*;

   logic [MUL_A_BITS-1:0] a_ff, a_in;
   logic [MUL_B_BITS-1:0] b_ff, b_in;
   logic [MUL_A_BITS-1:0] p_ff, p_in;

   // shift-add: one multiplier bit per cycle, stop when no bits remain
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      p_in = p_ff;
      if (load) begin
         a_in = a;
         b_in = b;
         p_in = '0;
      end else if (b_ff != '0) begin
         if (b_ff[0]) begin
            p_in = p_ff + a_ff;
         end
         a_in = {a_ff[MUL_A_BITS-2:0], 1'b0};
         b_in = {1'b0, b_ff[MUL_B_BITS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0;
      end else begin
         b_ff <= b_in;
      end
      a_ff <= a_in;
      p_ff <= p_in;
   end

   assign busy = (b_ff != '0);
   assign prod = p_ff;

endmodule
`default_nettype wire

[rtl/emr_datapath.sv]
`default_nettype none
module emr_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire emr_pkg::req_type             req_data,
   input  wire emr_pkg::cmd_type             cmd,
   input  wire logic                         csr_write,
   input  wire logic [emr_pkg::CSR_BITS-1:0] csr_index,
   input  wire logic [emr_pkg::COLOR_BITS-1:0] csr_data,
   output emr_pkg::status_type               status,
   output emr_pkg::rsp_type                  rsp_data
);
   import emr_pkg::*;

   // round a four-times value to nearest, ties to even
   function automatic logic [ACC_BITS-1:0] round_quarter(input logic [MUL_A_BITS-1:0] v);
      logic [ACC_BITS-1:0] q;
      logic                inc;
      q   = v[MUL_A_BITS-1:2];
      inc = (v[1:0] == 2'd3) || ((v[1:0] == 2'd2) && q[0]);
      return q + {{(ACC_BITS-1){1'b0}}, inc};
   endfunction

   logic                         outline_ff, fill_ff;
   logic [COLOR_BITS-1:0]        pen_ff, fcolor_ff;
   logic [COORD_BITS-1:0]        cx_ff, cy_ff;
   logic [AXIS_BITS-1:0]         rx_ff, ry_ff;
   logic signed [STEP_BITS-1:0]  sx_ff, sy_ff, px_ff, py_ff;
   logic signed [ACC_BITS-1:0]   dec_ff;
   logic signed [GRAD_BITS-1:0]  gx_ff, gy_ff;
   logic [SQ_BITS-1:0]           rx2_ff, ry2_ff;
   logic [MUL_B_BITS-1:0]        tmp_ff;
   logic [MUL_A_BITS-1:0]        acc_ff;
   logic                         brx_ff, bry_ff;
   rsp_type                      rsp_ff;

   logic                         brx, bry;
   logic signed [GRAD_BITS-1:0]  two_ry2, two_rx2;
   logic signed [ACC_BITS-1:0]   dec_delta;
   logic [MUL_A_BITS-1:0]        mul_a, prod, gy_v, p4;
   logic [MUL_B_BITS-1:0]        mul_b;
   logic                         mul_busy;
   logic [STEP_BITS:0]           tx, ym, ay;
   logic [COORD_BITS-1:0]        row_up, row_dn, x_lo, x_hi, x_sel, row_sel;

   assign two_ry2 = signed'({{(GRAD_BITS-SQ_BITS-1){1'b0}}, ry2_ff, 1'b0});
   assign two_rx2 = signed'({{(GRAD_BITS-SQ_BITS-1){1'b0}}, rx2_ff, 1'b0});

   // pick the axis moves of a step
   always_comb begin
      if (cmd.region == REGION_ONE) begin
         brx = 1'b1;
         bry = !dec_ff[ACC_BITS-1];
      end else begin
         bry = 1'b1;
         brx = dec_ff[ACC_BITS-1] || (dec_ff == '0);
      end
   end

   assign dec_delta = (brx_ff ? ACC_BITS'(gx_ff) : '0)
                    - (bry_ff ? ACC_BITS'(gy_ff) : '0)
                    + ((cmd.region == REGION_ONE) ? ACC_BITS'({1'b0, ry2_ff})
                                                  : ACC_BITS'({1'b0, rx2_ff}));

   // operands for the region-two set-up
   assign tx = {sx_ff, 1'b1};
   assign ym = {sy_ff[STEP_BITS-1], sy_ff} - 1'b1;
   assign ay = ym[STEP_BITS] ? (~ym + 1'b1) : ym;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_RX2: begin
            mul_a = MUL_A_BITS'(rx_ff);
            mul_b = MUL_B_BITS'(rx_ff);
         end
         OP_RY2: begin
            mul_a = MUL_A_BITS'(ry_ff);
            mul_b = MUL_B_BITS'(ry_ff);
         end
         OP_GY: begin
            mul_a = MUL_A_BITS'(rx2_ff);
            mul_b = MUL_B_BITS'(ry_ff);
         end
         OP_TX2: begin
            mul_a = MUL_A_BITS'(tx);
            mul_b = MUL_B_BITS'(tx);
         end
         OP_T1: begin
            mul_a = MUL_A_BITS'(ry2_ff);
            mul_b = tmp_ff;
         end
         OP_AY2: begin
            mul_a = MUL_A_BITS'(ay);
            mul_b = MUL_B_BITS'(ay);
         end
         OP_T2: begin
            mul_a = MUL_A_BITS'(rx2_ff);
            mul_b = tmp_ff;
         end
         OP_T3: begin
            mul_a = MUL_A_BITS'(rx2_ff);
            mul_b = MUL_B_BITS'(ry2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   emr_mul u_mul (
      .clock (clock),
      .reset (reset),
      .load  (cmd.mul_load),
      .a     (mul_a),
      .b     (mul_b),
      .busy  (mul_busy),
      .prod  (prod)
   );

   assign p4   = {prod[MUL_A_BITS-3:0], 2'b00};
   assign gy_v = MUL_A_BITS'({ry2_ff, 2'b00}) - p4 + MUL_A_BITS'(rx2_ff);

   // result word fields for the current slot
   assign row_up = cy_ff + py_ff[COORD_BITS-1:0];
   assign row_dn = cy_ff - py_ff[COORD_BITS-1:0];
   assign x_lo   = cx_ff - px_ff[COORD_BITS-1:0];
   assign x_hi   = cx_ff + px_ff[COORD_BITS-1:0];

   always_comb begin
      unique case (cmd.slot)
         3'd0, 3'd2, 3'd3: row_sel = row_up;
         default:          row_sel = row_dn;
      endcase
      unique case (cmd.slot)
         3'd2, 3'd4: x_sel = x_hi;
         default:    x_sel = x_lo;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outline_ff <= 1'b0;
         fill_ff    <= 1'b0;
         pen_ff     <= '0;
         fcolor_ff  <= '0;
         cx_ff      <= '0;
         cy_ff      <= '0;
         rx_ff      <= '0;
         ry_ff      <= '0;
         sx_ff      <= '0;
         sy_ff      <= '0;
         dec_ff     <= '0;
         gx_ff      <= '0;
         gy_ff      <= '0;
         rx2_ff     <= '0;
         ry2_ff     <= '0;
      end else begin
         // register writes
         if (csr_write) begin
            unique case (csr_index)
               CSR_OUTLINE: outline_ff <= csr_data[0];
               CSR_FILL:    fill_ff    <= csr_data[0];
               CSR_PEN:     pen_ff     <= csr_data;
               CSR_FCOLOR:  fcolor_ff  <= csr_data;
               default:     ;
            endcase
         end
         // load a new ellipse
         if (cmd.start) begin
            rx_ff <= req_data.rect_width[COORD_BITS-1:1];
            ry_ff <= req_data.rect_height[COORD_BITS-1:1];
            cx_ff <= req_data.origin_x + {1'b0, req_data.rect_width[COORD_BITS-1:1]};
            cy_ff <= req_data.origin_y + {1'b0, req_data.rect_height[COORD_BITS-1:1]};
            sx_ff <= '0;
            sy_ff <= STEP_BITS'({1'b0, req_data.rect_height[COORD_BITS-1:1]});
            gx_ff <= '0;
         end
         // advance the point and the gradients
         if (cmd.step) begin
            if (brx) begin
               sx_ff <= sx_ff + 1'b1;
               gx_ff <= gx_ff + two_ry2;
            end
            if (bry) begin
               sy_ff <= sy_ff - 1'b1;
               gy_ff <= gy_ff - two_rx2;
            end
         end
         if (cmd.decide) begin
            dec_ff <= dec_ff + dec_delta;
         end
         // take a finished product
         if (cmd.mul_commit) begin
            unique case (cmd.op)
               OP_RX2: rx2_ff <= prod[SQ_BITS-1:0];
               OP_RY2: ry2_ff <= prod[SQ_BITS-1:0];
               OP_GY: begin
                  gy_ff  <= {prod[GRAD_BITS-2:0], 1'b0};
                  dec_ff <= round_quarter(gy_v);
               end
               OP_TX2, OP_AY2: ;
               OP_T1: ;
               OP_T2: ;
               OP_T3: dec_ff <= round_quarter(acc_ff - p4);
               default: ;
            endcase
         end
      end
   end

   // scratch and snapshot registers
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         px_ff  <= sx_ff;
         py_ff  <= sy_ff;
         brx_ff <= brx;
         bry_ff <= bry;
      end
      if (cmd.mul_commit) begin
         if ((cmd.op == OP_TX2) || (cmd.op == OP_AY2)) begin
            tmp_ff <= prod[MUL_B_BITS-1:0];
         end
         if (cmd.op == OP_T1) begin
            acc_ff <= prod;
         end
         if (cmd.op == OP_T2) begin
            acc_ff <= acc_ff + p4;
         end
      end
      if (cmd.emit) begin
         rsp_ff.kind     <= (cmd.slot[2:1] == 2'd0) ? KIND_SPAN : KIND_POINT;
         rsp_ff.row      <= row_sel;
         rsp_ff.x_first  <= (cmd.slot[2:1] == 2'd0) ? x_lo : x_sel;
         rsp_ff.x_last   <= (cmd.slot[2:1] == 2'd0) ? x_hi : x_sel;
         rsp_ff.color    <= (cmd.slot[2:1] == 2'd0) ? fcolor_ff : pen_ff;
         rsp_ff.last     <= cmd.last;
         rsp_ff.finished <= cmd.finished;
      end
   end

   assign status.outline_en = outline_ff;
   assign status.fill_en    = fill_ff;
   assign status.py_zero    = (py_ff == '0);
   assign status.sy_neg     = sy_ff[STEP_BITS-1];
   assign status.gx_ge_gy   = (gx_ff >= gy_ff);
   assign status.mul_busy   = mul_busy;
   assign rsp_data          = rsp_ff;

endmodule
`default_nettype wire

[rtl/emr_ctrl.sv]
`default_nettype none
module emr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_func,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire emr_pkg::status_type status,
   output emr_pkg::cmd_type         cmd
);
   import emr_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_STEP  = 6'b000010,
      S_EMIT  = 6'b000100,
      S_MLOAD = 6'b001000,
      S_MWAIT = 6'b010000,
      S_CHECK = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] region_ff, region_in;
   mul_op_type op_ff, op_in;
   logic [2:0] slot_ff, slot_in;
   logic       fin_ff, fin_in;
   logic       sw_ff, sw_in;
   logic       valid_ff, valid_in;

   logic accept, slot_en, slot_last, out_free, emit, sw, fin;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !valid_ff || !rsp_stall;

   // which slots give a word this step
   always_comb begin
      unique case (slot_ff)
         3'd0: begin
            slot_en   = status.fill_en;
            slot_last = !(status.fill_en && !status.py_zero) && !status.outline_en;
         end
         3'd1: begin
            slot_en   = status.fill_en && !status.py_zero;
            slot_last = !status.outline_en;
         end
         3'd5: begin
            slot_en   = status.outline_en;
            slot_last = 1'b1;
         end
         default: begin
            slot_en   = status.outline_en;
            slot_last = 1'b0;
         end
      endcase
   end

   assign emit = (state_ff == S_EMIT) && slot_en && out_free;
   assign sw   = (region_ff == REGION_ONE) && status.gx_ge_gy;
   assign fin  = status.sy_neg && ((region_ff == REGION_TWO) || sw);

   always_comb begin
      state_in  = state_ff;
      region_in = region_ff;
      op_in     = op_ff;
      slot_in   = slot_ff;
      fin_in    = fin_ff;
      sw_in     = sw_ff;
      valid_in  = emit ? 1'b1 : (rsp_stall ? valid_ff : 1'b0);

      cmd            = '0;
      cmd.slot       = slot_ff;
      cmd.last       = slot_last;
      cmd.finished   = fin_ff;
      cmd.op         = op_ff;
      cmd.region     = region_ff;
      cmd.emit       = emit;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_START) begin
                  cmd.start = 1'b1;
                  region_in = REGION_ONE;
                  op_in     = OP_RX2;
                  state_in  = S_MLOAD;
               end else if (region_ff != REGION_IDLE) begin
                  cmd.step = 1'b1;
                  state_in = S_STEP;
               end
            end
         end
         // update the decision value and settle the region
         S_STEP: begin
            cmd.decide = 1'b1;
            fin_in     = fin;
            sw_in      = sw && !fin;
            slot_in    = 3'd0;
            if (fin) begin
               region_in = REGION_IDLE;
            end else if (sw) begin
               region_in = REGION_TWO;
            end
            state_in = S_EMIT;
         end
         // walk the six result slots
         S_EMIT: begin
            if (!slot_en || out_free) begin
               if (slot_ff == 3'd5) begin
                  if (sw_ff) begin
                     op_in    = OP_TX2;
                     state_in = S_MLOAD;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  slot_in = slot_ff + 3'd1;
               end
            end
         end
         S_MLOAD: begin
            cmd.mul_load = 1'b1;
            state_in     = S_MWAIT;
         end
         S_MWAIT: begin
            if (!status.mul_busy) begin
               cmd.mul_commit = 1'b1;
               priority if (op_ff == OP_GY) begin
                  state_in = S_CHECK;
               end else if (op_ff == OP_T3) begin
                  state_in = S_IDLE;
               end else begin
                  op_in    = mul_op_type'(op_ff + 3'd1);
                  state_in = S_MLOAD;
               end
            end
         end
         // region switch right after a start
         S_CHECK: begin
            if (status.gx_ge_gy) begin
               region_in = REGION_TWO;
               op_in     = OP_TX2;
               state_in  = S_MLOAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         region_ff <= REGION_IDLE;
         op_ff     <= OP_RX2;
         slot_ff   <= '0;
         fin_ff    <= 1'b0;
         sw_ff     <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         region_ff <= region_in;
         op_ff     <= op_in;
         slot_ff   <= slot_in;
         fin_ff    <= fin_in;
         sw_ff     <= sw_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

[rtl/midpoint_ellipse_rasterizer.sv]
`default_nettype none
// Start word: three shift-add multiplies, plus the region-two set-up when a zero
// semi-axis sends the ellipse straight to region two.
// Step word: an update state, then the six result slots, held while the output stalls;
// the single region switch adds five shift-add multiplies; the next word waits until idle.
// The shift-add multiplier sets the set-up time; the slot walk sets the step time.
// Synchronous active-high reset clears registers and the ellipse state; the block is idle.
module midpoint_ellipse_rasterizer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire emr_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output emr_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [emr_pkg::CSR_BITS-1:0]   csr_index,
   input  wire logic [emr_pkg::COLOR_BITS-1:0] csr_data
);
   import emr_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   emr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   emr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import emr_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 1000;
   localparam int PHASE_WORDS = 82;

   // Track the ellipse state and the pixel words it must produce
   class ellipse_scoreboard;
      bit outline_on, fill_on;
      logic [COLOR_BITS-1:0] pen_rgb, fill_rgb;
      longint cx, cy, sx, sy, dec, gx, gy, rx2, ry2;
      logic [1:0] region;
      rsp_type pending_pixels[$];
      int errors;

      function new();
         outline_on = 0; fill_on = 0; pen_rgb = '0; fill_rgb = '0;
         cx = 0; cy = 0; sx = 0; sy = 0; dec = 0; gx = 0; gy = 0; rx2 = 0; ry2 = 0;
         region = REGION_IDLE;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_BITS-1:0] idx, logic [COLOR_BITS-1:0] value);
         case (idx)
            CSR_OUTLINE: outline_on = value[0];
            CSR_FILL: fill_on = value[0];
            CSR_PEN: pen_rgb = value;
            CSR_FCOLOR: fill_rgb = value;
            default: ;
         endcase
      endfunction

      // keep the low ACC_BITS and sign extend
      function longint acc_wrap(longint v);
         logic [ACC_BITS-1:0] low;
         low = v[ACC_BITS-1:0];
         return {{(64-ACC_BITS){low[ACC_BITS-1]}}, low};
      endfunction

      // value held at four times scale, round half to even
      function longint quarter_round(bit [63:0] v4);
         bit [63:0] r;
         longint q;
         r = v4 & 64'd3;
         q = $signed(v4 - r) / 4;
         if (r == 3 || (r == 2 && q[0])) q = q + 1;
         return q;
      endfunction

      // switch to region two when the gradients cross, end once y goes negative
      function bit settle();
         bit [63:0] tx, ay, v;
         longint ym;
         if (region == REGION_ONE && gx >= gy) begin
            tx = 2 * sx + 1;
            ym = sy - 1;
            ay = (ym < 0) ? -ym : ym;
            v = 64'(ry2) * (tx * tx) + 4 * 64'(rx2) * (ay * ay) - 4 * 64'(rx2) * 64'(ry2);
            dec = acc_wrap(quarter_round(v));
            region = REGION_TWO;
         end
         if (region == REGION_TWO && sy < 0) begin
            region = REGION_IDLE;
            return 1;
         end
         return 0;
      endfunction

      function rsp_type pixel(logic kind, longint row, longint xa, longint xb,
                              logic [COLOR_BITS-1:0] rgb);
         rsp_type p;
         p.kind = kind; p.row = row[COORD_BITS-1:0];
         p.x_first = xa[COORD_BITS-1:0]; p.x_last = xb[COORD_BITS-1:0];
         p.color = rgb; p.last = 0; p.finished = 0;
         return p;
      endfunction

      function void note_word(req_type w);
         longint rx, ry;
         rsp_type step_px[$];
         bit done;
         if (w.func == FUNC_START) begin
            rx = w.rect_width >> 1;
            ry = w.rect_height >> 1;
            cx = longint'(w.origin_x) + rx;
            cy = longint'(w.origin_y) + ry;
            rx2 = rx * rx; ry2 = ry * ry;
            sx = 0; sy = ry; gx = 0; gy = 2 * rx2 * ry;
            dec = acc_wrap(quarter_round(64'(4 * ry2 - 4 * rx2 * ry + rx2)));
            region = REGION_ONE;
            void'(settle());
            return;
         end
         if (region == REGION_IDLE) return;
         if (fill_on) begin
            step_px.push_back(pixel(KIND_SPAN, cy + sy, cx - sx, cx + sx, fill_rgb));
            if (sy != 0) step_px.push_back(pixel(KIND_SPAN, cy - sy, cx - sx, cx + sx, fill_rgb));
         end
         if (outline_on) begin
            step_px.push_back(pixel(KIND_POINT, cy + sy, cx + sx, cx + sx, pen_rgb));
            step_px.push_back(pixel(KIND_POINT, cy + sy, cx - sx, cx - sx, pen_rgb));
            step_px.push_back(pixel(KIND_POINT, cy - sy, cx + sx, cx + sx, pen_rgb));
            step_px.push_back(pixel(KIND_POINT, cy - sy, cx - sx, cx - sx, pen_rgb));
         end
         // advance one midpoint step
         if (region == REGION_ONE) begin
            sx = sx + 1; gx = gx + 2 * ry2;
            if (dec < 0) dec = acc_wrap(dec + gx + ry2);
            else begin
               sy = sy - 1; gy = gy - 2 * rx2;
               dec = acc_wrap(dec + gx - gy + ry2);
            end
         end else begin
            sy = sy - 1; gy = gy - 2 * rx2;
            if (dec > 0) dec = acc_wrap(dec + rx2 - gy);
            else begin
               sx = sx + 1; gx = gx + 2 * ry2;
               dec = acc_wrap(dec + gx - gy + rx2);
            end
         end
         done = settle();
         foreach (step_px[i]) begin
            step_px[i].finished = done;
            step_px[i].last = (i == step_px.size() - 1);
            pending_pixels.push_back(step_px[i]);
         end
      endfunction

      function void compare(string field, longint exp_v, longint act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s expected %h actual %h", $time, field, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_word(rsp_type got);
         rsp_type exp_px;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected word, expected none actual %h", $time, got);
            errors++;
            return;
         end
         exp_px = pending_pixels.pop_front();
         compare("kind", exp_px.kind, got.kind);
         compare("row", exp_px.row, got.row);
         compare("x_first", exp_px.x_first, got.x_first);
         compare("x_last", exp_px.x_last, got.x_last);
         compare("color", exp_px.color, got.color);
         compare("last", exp_px.last, got.last);
         compare("finished", exp_px.finished, got.finished);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_BITS-1:0] csr_index = '0;
   logic [COLOR_BITS-1:0] csr_data = '0;

   ellipse_scoreboard sb = new();
   int burst_left = 0;
   int phase_words = 0;
   int hold_cycles = 0;
   bit hold_request = 0;
   int cycle_count = 0;

   midpoint_ellipse_rasterizer i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("midpoint_ellipse_rasterizer: mismatch");
         $finish;
      end
   end

   // stall the result side on a shifting pattern, plus one long hold
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall = 1;
      end else begin
         case ((cycle_count / 97) % 4)
            0: rsp_stall = 0;
            1: rsp_stall = ($urandom % 4) == 0;
            2: rsp_stall = ($urandom % 4) != 0;
            default: rsp_stall = (cycle_count % 3) == 0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_data);
   end

   // offer one word, holding it until accepted; bursts separated by gaps
   task send_word(req_type w);
      if (burst_left == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom % 4 == 0) ? 60 : $urandom_range(1, 20);
      end
      req_valid = 1;
      req_data = w;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
      burst_left--;
      phase_words++;
      @(negedge clock);
   endtask

   task draw_ellipse(logic [15:0] ox, logic [15:0] oy, logic [15:0] w, logic [15:0] h,
                     int steps);
      req_type word;
      word.func = FUNC_START;
      word.origin_x = ox; word.origin_y = oy;
      word.rect_width = w; word.rect_height = h;
      send_word(word);
      repeat (steps) begin
         word = req_type'({$urandom, $urandom, $urandom});
         word.func = FUNC_STEP;
         send_word(word);
      end
   endtask

   // drop valid and let the block drain completely
   task wait_idle();
      req_valid = 0;
      while (sb.pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task write_csr(logic [CSR_BITS-1:0] idx, logic [COLOR_BITS-1:0] value);
      csr_valid = 1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task set_mode(bit outline, bit fill, logic [31:0] pen, logic [31:0] fcol);
      write_csr(CSR_OUTLINE, {31'($urandom), outline});
      write_csr(CSR_FILL, {31'($urandom), fill});
      write_csr(CSR_PEN, pen);
      write_csr(CSR_FCOLOR, fcol);
   endtask

   // random ellipses, mostly small and drawn to completion
   task random_phase();
      int w, h, steps;
      req_type stray;
      while (phase_words < PHASE_WORDS) begin
         if ($urandom % 40 == 0) begin
            w = $urandom_range(0, 65535);
            h = $urandom_range(0, 65535);
         end else begin
            w = ($urandom % 8 == 0) ? $urandom_range(0, 2) : $urandom_range(0, 30);
            h = ($urandom % 8 == 0) ? $urandom_range(0, 2) : $urandom_range(0, 30);
         end
         steps = (w / 2) + (h / 2) + $urandom_range(1, 3);
         if (steps > 40 || $urandom % 6 == 0) steps = $urandom_range(1, 40);
         draw_ellipse(16'($urandom), 16'($urandom), 16'(w), 16'(h), steps);
         if ($urandom % 5 == 0) begin
            stray = req_type'({$urandom, $urandom, $urandom});
            stray.func = FUNC_STEP;
            send_word(stray);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, degenerate axes, restart, step while idle
      set_mode(1, 1, 32'h0, 32'hFFFF_FFFF);
      phase_words = 0;
      draw_ellipse(16'h0, 16'h0, 16'h0, 16'h0, 3);
      draw_ellipse(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3);
      draw_ellipse(16'hFFFA, 16'hFFFE, 16'd7, 16'd5, 6);
      draw_ellipse(16'd100, 16'd200, 16'd1, 16'd9, 6);
      draw_ellipse(16'd300, 16'd50, 16'd9, 16'd1, 7);
      draw_ellipse(16'd10, 16'd10, 16'hFFFF, 16'h0, 2);
      random_phase();
      wait_idle();

      set_mode(1, 0, 32'hFFFF_FFFF, $urandom);
      phase_words = 0;
      random_phase();
      wait_idle();

      set_mode(0, 1, $urandom, 32'h0);
      phase_words = 0;
      random_phase();
      wait_idle();

      set_mode(0, 0, $urandom, $urandom);
      phase_words = 0;
      random_phase();
      wait_idle();

      // long receiver hold while words keep coming
      set_mode(1, 1, $urandom, $urandom);
      phase_words = 0;
      hold_request = 1;
      random_phase();
      wait_idle();

      if (sb.errors == 0) begin
         $display("midpoint_ellipse_rasterizer: match");
      end else begin
         $display("midpoint_ellipse_rasterizer: mismatch");
      end
      $finish;
   end
endmodule

[midpoint_ellipse_rasterizer.f]
rtl/emr_pkg.sv
rtl/emr_mul.sv
rtl/emr_datapath.sv
rtl/emr_ctrl.sv
rtl/midpoint_ellipse_rasterizer.sv
bench/testbench.sv
